[rtl/wpm_pkg.sv]
// Shared types and constants for the wildcard pattern matcher.
package wpm_pkg;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEXT   = 2'd2,
    CMD_FINISH = 2'd3
  } cmd_t;

  localparam logic [7:0] STAR_BYTE     = 8'd42;
  localparam logic [7:0] QUESTION_BYTE = 8'd63;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic matched;
    logic overflow;
  } out_item_t;

  // Signals shared by every cell in the chain.
  typedef struct packed {
    logic       restart;
    logic       step;
    logic [7:0] data;
  } cell_ctrl_t;

  // What one cell hands to the next position.
  typedef struct packed {
    logic star_carry;
    logic advance;
  } link_t;

endpackage

[rtl/wpm_cell.sv]
// One pattern position: its stored byte, its active bit and the link to the next position.
module wpm_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  wpm_pkg::cell_ctrl_t ctrl,
  input  logic              seed,
  input  logic              load,
  input  logic              in_use,
  input  wpm_pkg::link_t    link_in,
  output wpm_pkg::link_t    link_out,
  output logic              closed
);

  logic [7:0] pat_r;
  logic       act_r;
  logic       act_nxt;
  logic       is_star;
  logic       hit;

  assign closed  = act_r | link_in.star_carry;
  assign is_star = in_use & (pat_r == wpm_pkg::STAR_BYTE);
  assign hit     = (pat_r == wpm_pkg::QUESTION_BYTE) | (pat_r == ctrl.data);

  assign link_out.star_carry = closed & is_star;
  assign link_out.advance    = closed & in_use & ~is_star & hit;

  always_comb begin
    act_nxt = act_r;
    if (ctrl.restart) begin
      act_nxt = seed;
    end else if (ctrl.step) begin
      act_nxt = (closed & is_star) | link_in.advance;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= seed;
    end else begin
      act_r <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pat_r <= ctrl.data;
    end
  end

endmodule

[rtl/wildcard_pattern_matcher.sv]
// Top level of the wildcard pattern matcher: command decode, cell chain and result register.
// The block takes one transfer per cycle for every command unless in_stall is high. Pattern
// bytes load into a chain of PATTERN_MAX cells, one byte per cell, and each text byte updates
// the active bits of all cells in the cycle it is accepted, with star closure rippling along
// the chain. An end command produces one result in an output register; the input is stalled
// only while that register holds a result that the receiver is stalling. A pattern longer
// than PATTERN_MAX bytes sets overflow and is reported as not matched until the next start.
module wildcard_pattern_matcher #(
  parameter int PATTERN_MAX = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  wpm_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output wpm_pkg::out_item_t out_data
);

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);

  logic               accept;
  logic               do_start;
  logic               do_append;
  logic               do_text;
  logic               do_finish;
  logic [LEN_W-1:0]   len_r;
  logic [LEN_W-1:0]   len_nxt;
  logic               ovf_r;
  logic               ovf_nxt;
  logic               last_r;
  logic               last_nxt;
  logic               full;
  logic               out_valid_r;
  wpm_pkg::out_item_t out_data_r;
  wpm_pkg::cell_ctrl_t ctrl;
  wpm_pkg::link_t     link [PATTERN_MAX+1];
  logic [PATTERN_MAX:0] closed;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    do_start  = 1'b0;
    do_append = 1'b0;
    do_text   = 1'b0;
    do_finish = 1'b0;
    unique case (in_data.command)
      wpm_pkg::CMD_START:  do_start  = accept;
      wpm_pkg::CMD_APPEND: do_append = accept;
      wpm_pkg::CMD_TEXT:   do_text   = accept;
      wpm_pkg::CMD_FINISH: do_finish = accept;
      default: ;
    endcase
  end

  assign full         = (len_r == LEN_W'(PATTERN_MAX));
  assign ctrl.restart = do_start | do_append | do_finish;
  assign ctrl.step    = do_text;
  assign ctrl.data    = in_data.byte_value;

  assign link[0] = '0;

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    wpm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .seed     (i == 0),
      .load     (do_append & (len_r == LEN_W'(i))),
      .in_use   (len_r > LEN_W'(i)),
      .link_in  (link[i]),
      .link_out (link[i+1]),
      .closed   (closed[i])
    );
  end

  assign closed[PATTERN_MAX] = last_r | link[PATTERN_MAX].star_carry;

  always_comb begin
    len_nxt  = len_r;
    ovf_nxt  = ovf_r;
    last_nxt = last_r;
    if (do_start) begin
      len_nxt = '0;
      ovf_nxt = 1'b0;
    end else if (do_append) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        len_nxt = len_r + LEN_W'(1);
      end
    end
    if (ctrl.restart) begin
      last_nxt = 1'b0;
    end else if (ctrl.step) begin
      last_nxt = link[PATTERN_MAX].advance;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      ovf_r       <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r  <= len_nxt;
      ovf_r  <= ovf_nxt;
      last_r <= last_nxt;
      if (do_finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_finish) begin
      out_data_r.matched  <= closed[len_r] & ~ovf_r;
      out_data_r.overflow <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/wpm_checker.sv]
// Port-level assertions for the wildcard pattern matcher and their binding.
module wpm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input wpm_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input wpm_pkg::out_item_t out_data
);

  logic finish_xfer;

  assign finish_xfer = in_valid & ~in_stall & (in_data.command == wpm_pkg::CMD_FINISH);

  // A stalled result stays on offer.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // No input transfer may overwrite a result that is still being stalled.
  a_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result is stalled");

  // An overflowed pattern never reports a match.
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.matched && out_data.overflow))
    else $error("match reported with overflow");

  // Every end-of-text transfer yields a result in the next cycle.
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    finish_xfer |=> out_valid)
    else $error("missing result after end of text");

  // No result appears without an end-of-text transfer.
  a_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !finish_xfer |=> !out_valid)
    else $error("result without end of text");

endmodule

bind wildcard_pattern_matcher wpm_checker u_wpm_checker (.*);

[tb/sv/tb_wildcard_pattern_matcher.sv]
// Self-checking testbench for the wildcard pattern matcher, with directed rows and random sequences.
`timescale 1ns / 100ps

module tb_wildcard_pattern_matcher;

  localparam int PATTERN_MAX  = 32;
  localparam int RANDOM_ITEMS = 1200;
  localparam int LONG_HOLD    = 400;
  localparam int SETTLE       = 20;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct {
    wpm_pkg::in_item_t  item;
    int                 count;
    bit                 has_exp;
    wpm_pkg::out_item_t exp;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  wpm_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  wpm_pkg::out_item_t out_data;

  // Golden copy of the matcher state.
  logic [7:0]         pat_mem [PATTERN_MAX];
  int unsigned        pat_len;
  bit [PATTERN_MAX:0] reach;
  bit                 ovf;

  wpm_pkg::out_item_t pending_results [$];
  dir_row_t           dir_rows [$];
  bit                 tag_has_exp;
  wpm_pkg::out_item_t tag_exp;
  bit                 hold_req;
  int                 error_count;
  int                 items_sent;
  int                 results_seen;
  int                 matches_seen;
  int                 overflows_seen;
  int                 burst_left;
  int unsigned        cycle_count = 0;

  wildcard_pattern_matcher #(.PATTERN_MAX(PATTERN_MAX)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void close_stars();
    for (int i = 0; i < pat_len && i < PATTERN_MAX; i++) begin
      if (reach[i] && pat_mem[i] == wpm_pkg::STAR_BYTE) reach[i + 1] = 1'b1;
    end
  endfunction

  function automatic void restart_text();
    reach    = '0;
    reach[0] = 1'b1;
  endfunction

  // Advances the golden state by one transfer; returns 1 when a result is due.
  function automatic bit glob_step(input wpm_pkg::in_item_t it,
                                   output wpm_pkg::out_item_t res);
    bit [PATTERN_MAX:0] nxt;
    bit                 produced;
    produced = 1'b0;
    res      = '0;
    case (it.command)
      wpm_pkg::CMD_START: begin
        pat_len = 0;
        ovf     = 1'b0;
        restart_text();
      end
      wpm_pkg::CMD_APPEND: begin
        if (pat_len < PATTERN_MAX) begin
          pat_mem[pat_len] = it.byte_value;
          pat_len++;
        end else begin
          ovf = 1'b1;
        end
        restart_text();
      end
      wpm_pkg::CMD_TEXT: begin
        close_stars();
        nxt = '0;
        for (int i = 0; i < pat_len && i < PATTERN_MAX; i++) begin
          if (reach[i]) begin
            if (pat_mem[i] == wpm_pkg::STAR_BYTE) nxt[i] = 1'b1;
            else if (pat_mem[i] == wpm_pkg::QUESTION_BYTE || pat_mem[i] == it.byte_value)
              nxt[i + 1] = 1'b1;
          end
        end
        reach = nxt;
      end
      default: begin
        close_stars();
        res.matched  = reach[pat_len] && !ovf;
        res.overflow = ovf;
        restart_text();
        produced = 1'b1;
      end
    endcase
    return produced;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    wpm_pkg::out_item_t predicted;
    wpm_pkg::out_item_t want;
    if (!rst_n) begin
      pat_len = 0;
      ovf     = 1'b0;
      restart_text();
    end else begin
      if (in_valid && !in_stall) begin
        if (glob_step(in_data, predicted))
          pending_results.push_back(tag_has_exp ? tag_exp : predicted);
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_data.matched) matches_seen++;
        if (out_data.overflow) overflows_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("result transfer with nothing pending", int'(out_data), 0);
        end else begin
          want = pending_results.pop_front();
          if (out_data.matched !== want.matched)
            report_mismatch("matched", int'(out_data.matched), int'(want.matched));
          if (out_data.overflow !== want.overflow)
            report_mismatch("overflow", int'(out_data.overflow), int'(want.overflow));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results pending.", cycle_count,
               pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : receiver
    int span;
    int mode;
    bit held;
    out_stall = 1'b0;
    held      = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        repeat (LONG_HOLD) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end
      span = $urandom_range(4, 40);
      mode = $urandom_range(0, 3);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= 1'($urandom_range(0, 1));
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  task automatic send_item(input wpm_pkg::in_item_t it, input bit has_exp,
                           input wpm_pkg::out_item_t exp);
    @(negedge clk);
    in_valid    <= 1'b1;
    in_data     <= it;
    tag_has_exp = has_exp;
    tag_exp     = exp;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      repeat ($urandom_range(0, 6)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
  endtask

  task automatic send_plain(input wpm_pkg::cmd_t cmd, input logic [7:0] b);
    wpm_pkg::in_item_t it;
    it.command    = cmd;
    it.byte_value = b;
    send_item(it, 1'b0, '0);
  endtask

  task automatic add_row(input wpm_pkg::cmd_t cmd, input logic [7:0] b, input int count,
                         input bit has_exp, input logic m, input logic o);
    dir_row_t r;
    r.item.command    = cmd;
    r.item.byte_value = b;
    r.count           = count;
    r.has_exp         = has_exp;
    r.exp.matched     = m;
    r.exp.overflow    = o;
    dir_rows.push_back(r);
  endtask

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 2) == 0) return 8'h61 + 8'($urandom_range(0, 1));
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [7:0] pick_pattern_byte();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) return wpm_pkg::STAR_BYTE;
    if (roll < 40) return wpm_pkg::QUESTION_BYTE;
    return pick_byte();
  endfunction

  // One start, one pattern and a few texts, each closed by an end command.
  task automatic run_sequence();
    logic [7:0] pat [$];
    int         plen;
    int         ntext;
    pat.delete();
    plen = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 8);
    send_plain(wpm_pkg::CMD_START, pick_byte());
    repeat (plen) pat.push_back(pick_pattern_byte());
    foreach (pat[k]) send_plain(wpm_pkg::CMD_APPEND, pat[k]);
    ntext = $urandom_range(1, 4);
    repeat (ntext) begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(0, 6)) send_plain(wpm_pkg::CMD_TEXT, pick_byte());
      end else begin
        foreach (pat[k]) begin
          if (pat[k] == wpm_pkg::STAR_BYTE)
            repeat ($urandom_range(0, 3)) send_plain(wpm_pkg::CMD_TEXT, pick_byte());
          else if (pat[k] == wpm_pkg::QUESTION_BYTE)
            send_plain(wpm_pkg::CMD_TEXT, pick_byte());
          else
            send_plain(wpm_pkg::CMD_TEXT, pat[k]);
        end
        if ($urandom_range(0, 4) == 0) send_plain(wpm_pkg::CMD_TEXT, pick_byte());
      end
      if ($urandom_range(0, 19) == 0) send_plain(wpm_pkg::CMD_APPEND, pick_pattern_byte());
      send_plain(wpm_pkg::CMD_FINISH, pick_byte());
    end
  endtask

  initial begin
    int random_target;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    hold_req    = 1'b0;
    tag_has_exp = 1'b0;
    tag_exp     = '0;
    burst_left  = 0;

    add_row(wpm_pkg::CMD_FINISH, 8'h00, 1, 1'b1, 1'b1, 1'b0);
    add_row(wpm_pkg::CMD_TEXT, 8'h61, 1, 1'b0, 1'b0, 1'b0);
    add_row(wpm_pkg::CMD_FINISH, 8'hFF, 1, 1'b1, 1'b0, 1'b0);
    add_row(wpm_pkg::CMD_START, 8'h00, 1, 1'b0, 1'b0, 1'b0);
    add_row(wpm_pkg::CMD_APPEND, wpm_pkg::STAR_BYTE, 1, 1'b0, 1'b0, 1'b0);
    add_row(wpm_pkg::CMD_FINISH, 8'h00, 1, 1'b1, 1'b1, 1'b0);
    add_row(wpm_pkg::CMD_TEXT, 8'hFF, 3, 1'b0, 1'b0, 1'b0);
    add_row(wpm_pkg::CMD_FINISH, 8'h00, 1, 1'b1, 1'b1, 1'b0);
    add_row(wpm_pkg::CMD_APPEND, wpm_pkg::QUESTION_BYTE, 1, 1'b0, 1'b0, 1'b0);
    add_row(wpm_pkg::CMD_APPEND, 8'h00, 1, 1'b0, 1'b0, 1'b0);
    add_row(wpm_pkg::CMD_TEXT, 8'h01, 1, 1'b0, 1'b0, 1'b0);
    add_row(wpm_pkg::CMD_TEXT, 8'h00, 1, 1'b0, 1'b0, 1'b0);
    add_row(wpm_pkg::CMD_FINISH, 8'h00, 1, 1'b0, 1'b0, 1'b0);
    add_row(wpm_pkg::CMD_TEXT, 8'h80, 1, 1'b0, 1'b0, 1'b0);
    add_row(wpm_pkg::CMD_FINISH, 8'h00, 1, 1'b0, 1'b0, 1'b0);
    add_row(wpm_pkg::CMD_START, 8'hFF, 1, 1'b0, 1'b0, 1'b0);
    add_row(wpm_pkg::CMD_APPEND, wpm_pkg::QUESTION_BYTE, PATTERN_MAX, 1'b0, 1'b0, 1'b0);
    add_row(wpm_pkg::CMD_TEXT, 8'hAA, PATTERN_MAX, 1'b0, 1'b0, 1'b0);
    add_row(wpm_pkg::CMD_FINISH, 8'h00, 1, 1'b0, 1'b0, 1'b0);
    add_row(wpm_pkg::CMD_APPEND, 8'h7F, 1, 1'b0, 1'b0, 1'b0);
    add_row(wpm_pkg::CMD_FINISH, 8'h00, 1, 1'b1, 1'b0, 1'b1);
    add_row(wpm_pkg::CMD_TEXT, 8'h01, 1, 1'b0, 1'b0, 1'b0);
    add_row(wpm_pkg::CMD_FINISH, 8'h00, 1, 1'b1, 1'b0, 1'b1);
    add_row(wpm_pkg::CMD_START, 8'h00, 1, 1'b0, 1'b0, 1'b0);
    add_row(wpm_pkg::CMD_FINISH, 8'h00, 1, 1'b1, 1'b1, 1'b0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) begin
      repeat (dir_rows[r].count) send_item(dir_rows[r].item, dir_rows[r].has_exp, dir_rows[r].exp);
    end

    hold_req      = 1'b1;
    random_target = items_sent + RANDOM_ITEMS;
    while (items_sent < random_target) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4))
          send_plain(wpm_pkg::cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else begin
        run_sequence();
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Sent %0d transfers and checked %0d results in %0d cycles.", items_sent,
             results_seen, cycle_count);
    $display("Results seen: %0d matched, %0d with overflow, %0d mismatches.", matches_seen,
             overflows_seen, error_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
